// File: src/bau_pkg.sv
// Buddy allocator package: shared codes, command/status structs and slot word.
// No dependencies; imported by every module of the buddy allocator unit.
package bau_pkg;

  localparam int ORD_W = 5;
  localparam int REQ_W = 17;
  localparam int OFF_W = 16;
  localparam int FB_W  = 17;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_WANT,
    ST_FIND,
    ST_POP_RD,
    ST_POP_TAKE,
    ST_SPLIT,
    ST_SLOT_RD,
    ST_SLOT_CHK,
    ST_MERGE_CHK,
    ST_BUDDY_CHK,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_MERGE,
    ST_PUSH,
    ST_RESULT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_WANT_STEP,
    OP_SET_WANT,
    OP_FIND_STEP,
    OP_POP_RD,
    OP_POP_TAKE,
    OP_SPLIT,
    OP_GRANT,
    OP_SLOT_RD,
    OP_FREE_MARK,
    OP_BUDDY_RD,
    OP_SRCH_RD,
    OP_SRCH_NEXT,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_MERGE,
    OP_PUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic want_more;
    logic want_fail;
    logic cur_over;
    logic cur_empty;
    logic split_more;
    logic off_ok;
    logic blk_ok;
    logic at_top;
    logic buddy_free;
    logic srch_end;
    logic match;
    logic shift_end;
  } dp_stat_t;

  typedef struct packed {
    logic [ORD_W-1:0] order;
    logic             free;
    logic             live;
  } slot_t;

endpackage

// File: src/bau_if.sv
// Request and response channel interfaces of the buddy allocator unit.
// Depends on bau_pkg for field widths.
interface bau_req_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [bau_pkg::REQ_W-1:0] request_bytes;
  logic [bau_pkg::OFF_W-1:0] free_offset;
  modport source (output valid, kind, request_bytes, free_offset, input ready);
  modport sink   (input valid, kind, request_bytes, free_offset, output ready);
endinterface

interface bau_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     granted;
  logic [bau_pkg::OFF_W-1:0] grant_offset;
  logic [bau_pkg::FB_W-1:0]  free_bytes;
  modport source (output valid, granted, grant_offset, free_bytes, input ready);
  modport sink   (input valid, granted, grant_offset, free_bytes, output ready);
endinterface

// File: src/buddy_allocator_unit.sv
// Buddy allocator unit top level: request/response channels, controller and datapath.
// Depends on bau_pkg, bau_if, bau_ctrl and bau_dp.
//
// Binary buddy allocator over a pool of 2^LOG2_POOL bytes with one FIFO free list per
// order, kept as rings in a single memory. One item is worked at a time and gives one
// beat back. After reset a clearing pass initializes the slot memory; no request is
// taken until it ends. An allocate rounds the size up one order at a time, searches the
// lists upward past empty ones, pops a block and splits it down one order at a time. A
// free marks the block, then at each level reads the buddy, stops on a busy buddy,
// walks the buddy's ring to find it, shifts the later entries down and merges; merging
// stops when the buddy is not found in its list. A rejected free goes straight to the
// result. A result waiting in the output register does not stop the next request from
// being taken.
module buddy_allocator_unit #(
  parameter int LOG2_MIN     = 5,
  parameter int LOG2_POOL    = 16,
  parameter int HEADER_BYTES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  bau_req_if.sink   req_i,
  bau_rsp_if.source rsp_o
);
  import bau_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bau_dp #(
    .LOG2_MIN     (LOG2_MIN),
    .LOG2_POOL    (LOG2_POOL),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (req_i.kind),
    .request_bytes_i (req_i.request_bytes),
    .free_offset_i   (req_i.free_offset),
    .granted_o       (rsp_o.granted),
    .grant_offset_o  (rsp_o.grant_offset),
    .free_bytes_o    (rsp_o.free_bytes)
  );

  // one item in flight: no second accept right after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while previous item still in work");

  // a grant only ever comes out of an allocate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_GRANT |-> !stat.is_free)
    else $error("grant issued for a free item");

  // loading the output register raises response valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> rsp_o.valid)
    else $error("result loaded but response not valid");

endmodule

// File: src/bau_ctrl.sv
// Buddy allocator controller: sequences allocate, split, free and merge steps.
// Depends on bau_pkg; drives the datapath by dp_cmd_t, reads dp_stat_t.
module bau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bau_pkg::dp_stat_t stat_i,
  output bau_pkg::dp_cmd_t  cmd_o
);
  import bau_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_NONE;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (stat_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!stat_i.is_free) state_d = ST_WANT;
        else if (stat_i.off_ok) state_d = ST_SLOT_RD;
        else state_d = ST_RESULT;
      end
      ST_WANT: begin
        if (stat_i.want_more) cmd_o.op = OP_WANT_STEP;
        else if (stat_i.want_fail) state_d = ST_RESULT;
        else begin
          cmd_o.op = OP_SET_WANT;
          state_d  = ST_FIND;
        end
      end
      ST_FIND: begin
        if (stat_i.cur_over) state_d = ST_RESULT;
        else if (stat_i.cur_empty) cmd_o.op = OP_FIND_STEP;
        else state_d = ST_POP_RD;
      end
      ST_POP_RD: begin
        cmd_o.op = OP_POP_RD;
        state_d  = ST_POP_TAKE;
      end
      ST_POP_TAKE: begin
        cmd_o.op = OP_POP_TAKE;
        state_d  = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (stat_i.split_more) cmd_o.op = OP_SPLIT;
        else begin
          cmd_o.op = OP_GRANT;
          state_d  = ST_RESULT;
        end
      end
      ST_SLOT_RD: begin
        cmd_o.op = OP_SLOT_RD;
        state_d  = ST_SLOT_CHK;
      end
      ST_SLOT_CHK: begin
        if (stat_i.blk_ok) begin
          cmd_o.op = OP_FREE_MARK;
          state_d  = ST_MERGE_CHK;
        end else state_d = ST_RESULT;
      end
      ST_MERGE_CHK: begin
        if (stat_i.at_top) state_d = ST_PUSH;
        else begin
          cmd_o.op = OP_BUDDY_RD;
          state_d  = ST_BUDDY_CHK;
        end
      end
      ST_BUDDY_CHK: begin
        state_d = stat_i.buddy_free ? ST_SRCH_RD : ST_PUSH;
      end
      ST_SRCH_RD: begin
        if (stat_i.srch_end) state_d = ST_PUSH;
        else begin
          cmd_o.op = OP_SRCH_RD;
          state_d  = ST_SRCH_CHK;
        end
      end
      ST_SRCH_CHK: begin
        if (stat_i.match) state_d = ST_SHIFT_RD;
        else begin
          cmd_o.op = OP_SRCH_NEXT;
          state_d  = ST_SRCH_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (stat_i.shift_end) state_d = ST_MERGE;
        else begin
          cmd_o.op = OP_SHIFT_RD;
          state_d  = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.op = OP_SHIFT_WR;
        state_d  = ST_SHIFT_RD;
      end
      ST_MERGE: begin
        cmd_o.op = OP_MERGE;
        state_d  = ST_MERGE_CHK;
      end
      ST_PUSH: begin
        cmd_o.op = OP_PUSH;
        state_d  = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: src/bau_dp.sv
// Buddy allocator datapath: slot memory, free-list ring memory, list heads and
// counts, pool byte count and result registers. Depends on bau_pkg.
module bau_dp #(
  parameter int LOG2_MIN     = 5,
  parameter int LOG2_POOL    = 16,
  parameter int HEADER_BYTES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bau_pkg::dp_cmd_t          cmd_i,
  output bau_pkg::dp_stat_t         stat_o,
  input  logic                      kind_i,
  input  logic [bau_pkg::REQ_W-1:0] request_bytes_i,
  input  logic [bau_pkg::OFF_W-1:0] free_offset_i,
  output logic                      granted_o,
  output logic [bau_pkg::OFF_W-1:0] grant_offset_o,
  output logic [bau_pkg::FB_W-1:0]  free_bytes_o
);
  import bau_pkg::*;

  localparam int SPAN   = LOG2_POOL - LOG2_MIN;
  localparam int NSLOTS = 1 << SPAN;
  localparam int NORD   = SPAN + 1;
  localparam int LDEPTH = 2 << SPAN;
  localparam int LA_W   = SPAN + 1;
  localparam int CNT_W  = SPAN + 1;
  localparam int OI_W   = (NORD > 1) ? $clog2(NORD) : 1;
  localparam int PW     = LOG2_POOL + 1;
  localparam int NEED_W = REQ_W + 1;

  // memories
  slot_t            slot_mem [NSLOTS];
  logic [SPAN-1:0]  list_mem [LDEPTH];
  slot_t            slot_rd_q;
  logic [SPAN-1:0]  list_rd_q;

  // control state
  logic [SPAN-1:0]  clr_q;
  logic [SPAN-1:0]  heads_q  [NORD];
  logic [CNT_W-1:0] counts_q [NORD];
  logic [PW-1:0]    pool_q;

  // working registers
  logic              kind_q;
  logic [NEED_W-1:0] need_q;
  logic [OFF_W-1:0]  off_q;
  logic [ORD_W-1:0]  o_q, want_q;
  logic [SPAN-1:0]   slot_q, buddy_q;
  logic [CNT_W-1:0]  p_q;
  logic              res_g_q;
  logic [OFF_W-1:0]  res_off_q;
  logic              out_g_q;
  logic [OFF_W-1:0]  out_off_q;
  logic [FB_W-1:0]   out_fb_q;

  function automatic logic [LA_W-1:0] ring_addr(logic [OI_W-1:0] i, logic [SPAN-1:0] head,
                                                logic [CNT_W-1:0] pos);
    logic [31:0] base, msk, offs;
    base = (32'(2) << SPAN) - ((32'(2) << SPAN) >> i);
    msk  = ((32'(1) << SPAN) >> i) - 32'(1);
    offs = (32'(head) + 32'(pos)) & msk;
    return LA_W'(base + offs);
  endfunction

  function automatic logic [CNT_W-1:0] ring_cap(logic [OI_W-1:0] i);
    return CNT_W'((32'(1) << SPAN) >> i);
  endfunction

  logic [OI_W-1:0]  idx_c, idx_m1;
  logic [ORD_W-1:0] o_m1, o_p1;
  logic [SPAN-1:0]  half_c, buddy_c, merged_c, start_slot_c;
  logic [31:0]      start_c;
  logic             push_ok_c, split_ok_c;

  assign idx_c    = OI_W'(int'(o_q) - LOG2_MIN);
  assign idx_m1   = OI_W'(int'(o_q) - 1 - LOG2_MIN);
  assign o_m1     = o_q - ORD_W'(1);
  assign o_p1     = o_q + ORD_W'(1);
  assign half_c   = slot_q + SPAN'(32'(1) << (int'(o_q) - 1 - LOG2_MIN));
  assign buddy_c  = slot_q ^ SPAN'(32'(1) << (int'(o_q) - LOG2_MIN));
  assign merged_c = (buddy_q < slot_q) ? buddy_q : slot_q;
  assign start_c  = 32'(free_offset_i) - 32'(HEADER_BYTES);
  assign start_slot_c = SPAN'(start_c >> LOG2_MIN);
  assign push_ok_c  = counts_q[idx_c] < ring_cap(idx_c);
  assign split_ok_c = counts_q[idx_m1] < ring_cap(idx_m1);

  // memory port control
  logic            slot_we, slot_re, list_we, list_re;
  logic [SPAN-1:0] slot_wa, slot_ra, list_wd;
  slot_t           slot_wd;
  logic [LA_W-1:0] list_wa, list_ra;

  always_comb begin
    slot_we = 1'b0;
    slot_re = 1'b0;
    list_we = 1'b0;
    list_re = 1'b0;
    slot_wa = slot_q;
    slot_ra = slot_q;
    slot_wd = '0;
    list_wa = '0;
    list_ra = '0;
    list_wd = slot_q;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr_q;
        if (clr_q == '0) slot_wd = '{order: ORD_W'(LOG2_POOL), free: 1'b1, live: 1'b0};
        // top-order ring holds slot 0 after reset
        list_we = (clr_q == '0);
        list_wa = ring_addr(OI_W'(SPAN), '0, '0);
        list_wd = '0;
      end
      OP_POP_RD: begin
        list_re = 1'b1;
        list_ra = ring_addr(idx_c, heads_q[idx_c], '0);
      end
      OP_SPLIT: begin
        slot_we = 1'b1;
        slot_wa = half_c;
        slot_wd = '{order: o_m1, free: 1'b1, live: 1'b0};
        list_we = split_ok_c;
        list_wa = ring_addr(idx_m1, heads_q[idx_m1], counts_q[idx_m1]);
        list_wd = half_c;
      end
      OP_GRANT: begin
        slot_we = 1'b1;
        slot_wd = '{order: want_q, free: 1'b0, live: 1'b1};
      end
      OP_SLOT_RD: slot_re = 1'b1;
      OP_FREE_MARK: begin
        slot_we = 1'b1;
        slot_wd = '{order: slot_rd_q.order, free: 1'b1, live: 1'b0};
      end
      OP_BUDDY_RD: begin
        slot_re = 1'b1;
        slot_ra = buddy_c;
      end
      OP_SRCH_RD: begin
        list_re = 1'b1;
        list_ra = ring_addr(idx_c, heads_q[idx_c], p_q);
      end
      OP_SHIFT_RD: begin
        list_re = 1'b1;
        list_ra = ring_addr(idx_c, heads_q[idx_c], p_q + CNT_W'(1));
      end
      OP_SHIFT_WR: begin
        list_we = 1'b1;
        list_wa = ring_addr(idx_c, heads_q[idx_c], p_q);
        list_wd = list_rd_q;
      end
      OP_MERGE: begin
        slot_we = 1'b1;
        slot_wa = merged_c;
        slot_wd = '{order: o_p1, free: 1'b1, live: 1'b0};
      end
      OP_PUSH: begin
        list_we = push_ok_c;
        list_wa = ring_addr(idx_c, heads_q[idx_c], counts_q[idx_c]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_rd_q <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) list_mem[list_wa] <= list_wd;
    if (list_re) list_rd_q <= list_mem[list_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      pool_q <= PW'(32'(1) << LOG2_POOL);
      for (int i = 0; i < NORD; i++) begin
        heads_q[i]  <= '0;
        counts_q[i] <= (i == NORD - 1) ? CNT_W'(1) : '0;
      end
    end else begin
      unique case (cmd_i.op)
        OP_CLEAR: clr_q <= clr_q + SPAN'(1);
        OP_POP_RD: begin
          heads_q[idx_c]  <= SPAN'((32'(heads_q[idx_c]) + 32'(1))
                                   & (32'(ring_cap(idx_c)) - 32'(1)));
          counts_q[idx_c] <= counts_q[idx_c] - CNT_W'(1);
        end
        OP_SPLIT: if (split_ok_c) counts_q[idx_m1] <= counts_q[idx_m1] + CNT_W'(1);
        OP_GRANT: pool_q <= pool_q - PW'(32'(1) << want_q);
        OP_FREE_MARK: pool_q <= pool_q + PW'(32'(1) << slot_rd_q.order);
        OP_MERGE: counts_q[idx_c] <= counts_q[idx_c] - CNT_W'(1);
        OP_PUSH: if (push_ok_c) counts_q[idx_c] <= counts_q[idx_c] + CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        kind_q    <= kind_i;
        need_q    <= NEED_W'(request_bytes_i) + NEED_W'(HEADER_BYTES);
        off_q     <= free_offset_i;
        o_q       <= ORD_W'(LOG2_MIN);
        slot_q    <= start_slot_c;
        res_g_q   <= 1'b0;
        res_off_q <= '0;
      end
      OP_WANT_STEP, OP_FIND_STEP: o_q <= o_p1;
      OP_SET_WANT: want_q <= o_q;
      OP_POP_TAKE: slot_q <= list_rd_q;
      OP_SPLIT: o_q <= o_m1;
      OP_GRANT: begin
        res_g_q   <= 1'b1;
        res_off_q <= OFF_W'((32'(slot_q) << LOG2_MIN) + 32'(HEADER_BYTES));
      end
      OP_FREE_MARK: o_q <= slot_rd_q.order;
      OP_BUDDY_RD: begin
        buddy_q <= buddy_c;
        p_q     <= '0;
      end
      OP_SRCH_NEXT, OP_SHIFT_WR: p_q <= p_q + CNT_W'(1);
      OP_MERGE: begin
        slot_q <= merged_c;
        o_q    <= o_p1;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_g_q   <= res_g_q;
      out_off_q <= res_off_q;
      out_fb_q  <= FB_W'(pool_q);
    end
  end

  logic [31:0] off_start_c;
  assign off_start_c = 32'(off_q) - 32'(HEADER_BYTES);

  always_comb begin
    stat_o.clr_done   = (clr_q == SPAN'(NSLOTS - 1));
    stat_o.is_free    = kind_q;
    stat_o.want_fail  = (32'(1) << o_q) < 32'(need_q);
    stat_o.want_more  = (int'(o_q) < LOG2_POOL) && stat_o.want_fail;
    stat_o.cur_over   = int'(o_q) > LOG2_POOL;
    stat_o.cur_empty  = (counts_q[idx_c] == '0);
    stat_o.split_more = o_q > want_q;
    stat_o.off_ok     = (off_q != '0) && (32'(off_q) >= 32'(HEADER_BYTES))
                      && ((off_start_c & ((32'(1) << LOG2_MIN) - 32'(1))) == '0)
                      && ((off_start_c >> LOG2_MIN) < 32'(NSLOTS));
    stat_o.blk_ok     = slot_rd_q.live && (int'(slot_rd_q.order) >= LOG2_MIN)
                      && (int'(slot_rd_q.order) <= LOG2_POOL);
    stat_o.at_top     = int'(o_q) >= LOG2_POOL;
    stat_o.buddy_free = slot_rd_q.free;
    stat_o.srch_end   = (32'(p_q) >= 32'(counts_q[idx_c]));
    stat_o.match      = (list_rd_q == buddy_q);
    stat_o.shift_end  = (32'(p_q) + 32'(1) >= 32'(counts_q[idx_c]));
  end

  assign granted_o      = out_g_q;
  assign grant_offset_o = out_off_q;
  assign free_bytes_o   = out_fb_q;

endmodule
